// ----- hdl/pead_pkg.sv -----
`default_nettype none

package pead_pkg;

   localparam int unsigned LevelWidth  = 40;
   localparam int unsigned ButtonWidth = 32;
   localparam int unsigned AxisWidth   = 8;
   localparam int unsigned CenterWidth = 8;
   localparam int unsigned ThreshWidth = 7;
   localparam int unsigned CountWidth  = 4;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 8;

   localparam logic [CenterWidth-1:0] CenterReset = 8'd128;
   localparam logic [ThreshWidth-1:0] ThreshReset = 7'd64;
   localparam logic [CountWidth-1:0]  DelayReset  = 4'd10;
   localparam logic [CountWidth-1:0]  ReloadReset = 4'd6;
   localparam logic [CountWidth-1:0]  CountMax    = 4'd15;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_ANALOG_CENTER    = 2'd0,
      CSR_ANALOG_THRESHOLD = 2'd1,
      CSR_REPEAT_DELAY     = 2'd2,
      CSR_FAST_RELOAD      = 2'd3
   } csr_index_type;

   // bit 0: below low bound (up / left), bit 1: above high bound (down / right)
   function automatic logic [1:0] axis_dirs(input logic [AxisWidth-1:0] axis,
                                            input logic signed [9:0] lo,
                                            input logic signed [9:0] hi);
      logic signed [9:0] v;
      logic [1:0] dirs;
      v = signed'({2'b00, axis});
      dirs = 2'b00;
      if (v < lo) begin
         dirs = 2'b01;
      end else if (v > hi) begin
         dirs = 2'b10;
      end
      return dirs;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/pad_edge_and_autorepeat.sv -----
// Controller poll edge detector with two auto-repeat masks. Each item is one poll (32 button
// bits and four stick axes); the block forms a 40-bit level word with the stick directions in
// bits 32-39 (LU,LD,LL,LR,RU,RD,RL,RR), and returns that word, press and release masks against
// the last differing word, and fast and slow repeat masks that start after repeat_delay equal
// polls. One item is accepted every clock cycle unless req_stall is high, which happens
// when the input register holds an item and the result register is blocked by rsp_stall.
// Each item passes through an input register, then one pass of compare, mask and 4-bit
// counter logic into the result register. That single pass, which also updates the previous
// word and the repeat counters, sets the rate. Configuration writes are always taken
// (csr_ready is tied high) and take effect for items that reach the compare stage afterwards.
`default_nettype none

module pad_edge_and_autorepeat (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [pead_pkg::ButtonWidth-1:0]      req_raw_buttons,
   input  wire logic [pead_pkg::AxisWidth-1:0]        req_left_x,
   input  wire logic [pead_pkg::AxisWidth-1:0]        req_left_y,
   input  wire logic [pead_pkg::AxisWidth-1:0]        req_right_x,
   input  wire logic [pead_pkg::AxisWidth-1:0]        req_right_y,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [pead_pkg::LevelWidth-1:0]            rsp_level_mask,
   output logic [pead_pkg::LevelWidth-1:0]            rsp_press_mask,
   output logic [pead_pkg::LevelWidth-1:0]            rsp_release_mask,
   output logic [pead_pkg::LevelWidth-1:0]            rsp_fast_repeat_mask,
   output logic [pead_pkg::LevelWidth-1:0]            rsp_slow_repeat_mask,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pead_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire logic [pead_pkg::CsrDataWidth-1:0]     csr_wdata
);

   // configuration
   logic [pead_pkg::CenterWidth-1:0] center_ff;
   logic [pead_pkg::ThreshWidth-1:0] thresh_ff;
   logic [pead_pkg::CountWidth-1:0]  delay_ff;
   logic [pead_pkg::CountWidth-1:0]  reload_ff;

   // input stage
   logic                             s1_valid_ff;
   logic [pead_pkg::ButtonWidth-1:0] s1_buttons_ff;
   logic [pead_pkg::AxisWidth-1:0]   s1_left_x_ff;
   logic [pead_pkg::AxisWidth-1:0]   s1_left_y_ff;
   logic [pead_pkg::AxisWidth-1:0]   s1_right_x_ff;
   logic [pead_pkg::AxisWidth-1:0]   s1_right_y_ff;

   // poll history
   logic [pead_pkg::LevelWidth-1:0]  prev_ff;
   logic [pead_pkg::CountWidth-1:0]  fast_count_ff;
   logic [pead_pkg::CountWidth-1:0]  slow_count_ff;
   logic [pead_pkg::LevelWidth-1:0]  prev_in;
   logic [pead_pkg::CountWidth-1:0]  fast_count_in;
   logic [pead_pkg::CountWidth-1:0]  slow_count_in;

   // result stage
   logic                             rsp_valid_ff;
   logic [pead_pkg::LevelWidth-1:0]  level_ff;
   logic [pead_pkg::LevelWidth-1:0]  press_ff;
   logic [pead_pkg::LevelWidth-1:0]  release_ff;
   logic [pead_pkg::LevelWidth-1:0]  fast_ff;
   logic [pead_pkg::LevelWidth-1:0]  slow_ff;
   logic [pead_pkg::LevelWidth-1:0]  level_in;
   logic [pead_pkg::LevelWidth-1:0]  press_in;
   logic [pead_pkg::LevelWidth-1:0]  release_in;
   logic [pead_pkg::LevelWidth-1:0]  fast_in;
   logic [pead_pkg::LevelWidth-1:0]  slow_in;

   logic                             out_advance;
   logic                             req_take;
   logic                             s1_move;
   logic signed [9:0]                bound_lo;
   logic signed [9:0]                bound_hi;
   logic [pead_pkg::CountWidth-1:0]  fast_inc;
   logic [pead_pkg::CountWidth-1:0]  slow_inc;
   logic                             same_word;

   assign csr_ready   = 1'b1;
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_move     = s1_valid_ff && out_advance;
   assign req_stall   = s1_valid_ff && !out_advance;
   assign req_take    = req_valid && !req_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_level_mask       = level_ff;
   assign rsp_press_mask       = press_ff;
   assign rsp_release_mask     = release_ff;
   assign rsp_fast_repeat_mask = fast_ff;
   assign rsp_slow_repeat_mask = slow_ff;

   always_comb begin
      bound_lo = signed'({2'b00, center_ff}) - signed'({3'b000, thresh_ff});
      bound_hi = signed'({2'b00, center_ff}) + signed'({3'b000, thresh_ff});

      level_in = {pead_pkg::axis_dirs(s1_right_x_ff, bound_lo, bound_hi),
                  pead_pkg::axis_dirs(s1_right_y_ff, bound_lo, bound_hi),
                  pead_pkg::axis_dirs(s1_left_x_ff, bound_lo, bound_hi),
                  pead_pkg::axis_dirs(s1_left_y_ff, bound_lo, bound_hi),
                  s1_buttons_ff};
      press_in   = level_in & ~prev_ff;
      release_in = ~level_in & prev_ff;
      same_word  = (level_in == prev_ff);

      fast_inc = (fast_count_ff == pead_pkg::CountMax) ? pead_pkg::CountMax
                                                       : fast_count_ff + 4'd1;
      slow_inc = (slow_count_ff == pead_pkg::CountMax) ? pead_pkg::CountMax
                                                       : slow_count_ff + 4'd1;

      fast_in       = press_in;
      slow_in       = press_in;
      prev_in       = prev_ff;
      fast_count_in = '0;
      slow_count_in = '0;
      if (same_word) begin
         fast_count_in = fast_inc;
         if (fast_inc >= delay_ff) begin
            fast_in       = level_in;
            fast_count_in = reload_ff;
         end
         slow_count_in = slow_inc;
         if (slow_inc >= delay_ff) begin
            slow_in       = level_in;
            slow_count_in = delay_ff;
         end
      end else begin
         prev_in = level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff     <= pead_pkg::CenterReset;
         thresh_ff     <= pead_pkg::ThreshReset;
         delay_ff      <= pead_pkg::DelayReset;
         reload_ff     <= pead_pkg::ReloadReset;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_ff       <= '0;
         fast_count_ff <= '0;
         slow_count_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (pead_pkg::csr_index_type'(csr_index))
               pead_pkg::CSR_ANALOG_CENTER: begin
                  center_ff <= csr_wdata;
               end
               pead_pkg::CSR_ANALOG_THRESHOLD: begin
                  thresh_ff <= csr_wdata[pead_pkg::ThreshWidth-1:0];
               end
               pead_pkg::CSR_REPEAT_DELAY: begin
                  delay_ff <= csr_wdata[pead_pkg::CountWidth-1:0];
               end
               pead_pkg::CSR_FAST_RELOAD: begin
                  reload_ff <= csr_wdata[pead_pkg::CountWidth-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            prev_ff       <= prev_in;
            fast_count_ff <= fast_count_in;
            slow_count_ff <= slow_count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_buttons_ff <= req_raw_buttons;
         s1_left_x_ff  <= req_left_x;
         s1_left_y_ff  <= req_left_y;
         s1_right_x_ff <= req_right_x;
         s1_right_y_ff <= req_right_y;
      end
      if (s1_move) begin
         level_ff   <= level_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         fast_ff    <= fast_in;
         slow_ff    <= slow_in;
      end
   end

`ifndef SYNTHESIS
   // a pressed bit is never also released in the same item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((press_ff & release_ff) == '0))
      else $error("press and release masks overlap");

   // repeat masks lie between press and level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((press_ff & ~fast_ff) == '0) && ((fast_ff & ~level_ff) == '0)
                        && ((press_ff & ~slow_ff) == '0) && ((slow_ff & ~level_ff) == '0)))
      else $error("repeat mask outside press/level bounds");

   // one stick axis never reports both directions
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((level_ff[33:32] != 2'b11) && (level_ff[35:34] != 2'b11)
                        && (level_ff[37:36] != 2'b11) && (level_ff[39:38] != 2'b11)))
      else $error("opposite stick directions both set");

   // a held input item is not dropped while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_advance) |=> (s1_valid_ff && $stable(s1_buttons_ff)))
      else $error("input stage item lost under stall");
`endif

endmodule

`default_nettype wire
